/* hdl/ofblr_pkg.sv */
package ofblr_pkg;

   // field widths
   localparam int LEVEL_W   = 10;
   localparam int PERIOD_W  = 16;
   localparam int CHAR_W    = 7;
   localparam int PATTERN_W = 5;
   localparam int INDEX_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ON_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_OFF_TICKS = 2'd2;

   // register reset values
   localparam logic [LEVEL_W-1:0]  ON_THRESHOLD_RST   = 10'd600;
   localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST     = 16'd100;
   localparam logic [PERIOD_W-1:0] SYNC_OFF_TICKS_RST = 16'd3000;

   // index of the fifth bit of a letter
   localparam logic [INDEX_W-1:0] LAST_BIT_INDEX = 3'd4;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_A       = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
   localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3f;

   // letter patterns and the space pattern
   localparam logic [PATTERN_W-1:0] PAT_FIRST_LETTER = 5'd1;
   localparam logic [PATTERN_W-1:0] PAT_LAST_LETTER  = 5'd26;
   localparam logic [PATTERN_W-1:0] PAT_SPACE        = 5'd31;

   // pattern to ascii
   function automatic logic [CHAR_W-1:0] decode_letter(input logic [PATTERN_W-1:0] pat);
      logic [CHAR_W-1:0] code;
      if (pat inside {[PAT_FIRST_LETTER:PAT_LAST_LETTER]}) begin
         code = CHAR_A + {2'b00, pat} - 7'd1;
      end else if (pat == PAT_SPACE) begin
         code = CHAR_SPACE;
      end else begin
         code = CHAR_UNKNOWN;
      end
      return code;
   endfunction

endpackage

/* hdl/ofblr_if.sv */
// sensor sample channel
interface ofblr_req_if import ofblr_pkg::*;;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] light_level;

   modport source  (output valid, output light_level, input ready);
   modport sink    (input valid, input light_level, output ready);
   modport monitor (input valid, input light_level, input ready);
endinterface

// decoded letter channel
interface ofblr_rsp_if import ofblr_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CHAR_W-1:0]    character;
   logic [PATTERN_W-1:0] bit_pattern;

   modport source  (output valid, output character, output bit_pattern, input ready);
   modport sink    (input valid, input character, input bit_pattern, output ready);
   modport monitor (input valid, input character, input bit_pattern, input ready);
endinterface

// register write channel
interface ofblr_csr_if import ofblr_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source  (output valid, output index, output data, input ready);
   modport sink    (input valid, input index, input data, output ready);
   modport monitor (input valid, input index, input data, input ready);
endinterface

/* hdl/optical_five_bit_letter_receiver_unit.sv */
// channel   | dir | payload                              | handshake
// req_chan  | in  | light_level[9:0]                     | valid/ready
// rsp_chan  | out | character[6:0], bit_pattern[4:0]     | valid/ready
// csr_chan  | in  | index[1:0], data[15:0]               | valid/ready, always ready
//
// one sample transaction per cycle while the result register is not stalled:
// an input register feeds one step of the receiver state machine, which loads
// the result register; the letter that a sample completes appears from there.
// reset (synchronous, active high) returns to waiting for light on and restores
// register defaults. a stalled result holds the result register and the input
// register; req_chan is ready only while the input register is empty or moves.
module optical_five_bit_letter_receiver_unit
   import ofblr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ofblr_req_if.sink   req_chan,
   ofblr_rsp_if.source rsp_chan,
   ofblr_csr_if.sink   csr_chan
);

   typedef enum logic [1:0] {
      PH_WAIT_ON,
      PH_WAIT_OFF,
      PH_OFF_CNT,
      PH_SAMPLE
   } phase_type;

   // configuration
   logic [LEVEL_W-1:0]  on_threshold_ff, on_threshold_in;
   logic [PERIOD_W-1:0] bit_period_ff, bit_period_in;
   logic [PERIOD_W-1:0] sync_off_ticks_ff, sync_off_ticks_in;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [LEVEL_W-1:0] in_level_ff, in_level_in;

   // receiver state
   phase_type            phase_ff, phase_in;
   logic [PERIOD_W-1:0]  tick_count_ff, tick_count_in;
   logic [PATTERN_W-1:0] bits_so_far_ff, bits_so_far_in;
   logic [INDEX_W-1:0]   bit_index_ff, bit_index_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic [PATTERN_W-1:0] rsp_pattern_ff, rsp_pattern_in;

   logic                 advance;
   logic                 req_accept;
   logic                 light_on;
   logic [PERIOD_W-1:0]  off_count;
   logic [PATTERN_W-1:0] bits_next;

   assign advance    = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && req_chan.ready;
   assign light_on   = in_level_ff > on_threshold_ff;
   assign off_count  = (tick_count_ff == '1) ? tick_count_ff : tick_count_ff + 16'd1;
   assign bits_next  = {bits_so_far_ff[PATTERN_W-2:0], light_on};

   assign req_chan.ready       = !in_valid_ff || advance;
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.character   = rsp_char_ff;
   assign rsp_chan.bit_pattern = rsp_pattern_ff;

   // register writes
   always_comb begin
      on_threshold_in   = on_threshold_ff;
      bit_period_in     = bit_period_ff;
      sync_off_ticks_in = sync_off_ticks_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_ON_THRESHOLD:   on_threshold_in   = csr_chan.data[LEVEL_W-1:0];
            CSR_BIT_PERIOD:     bit_period_in     = csr_chan.data;
            CSR_SYNC_OFF_TICKS: sync_off_ticks_in = csr_chan.data;
            default:            ;
         endcase
      end
   end

   // input stage
   always_comb begin
      in_valid_in = req_accept || (in_valid_ff && !advance);
      in_level_in = req_accept ? req_chan.light_level : in_level_ff;
   end

   // receiver step and result load
   always_comb begin
      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      bits_so_far_in = bits_so_far_ff;
      bit_index_in   = bit_index_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in    = rsp_char_ff;
      rsp_pattern_in = rsp_pattern_ff;
      if (in_valid_ff && advance) begin
         case (phase_ff)
            PH_WAIT_ON: begin
               if (light_on) begin
                  phase_in = PH_WAIT_OFF;
               end
            end
            PH_WAIT_OFF: begin
               if (!light_on) begin
                  phase_in      = PH_OFF_CNT;
                  tick_count_in = '0;
               end
            end
            PH_OFF_CNT: begin
               if (light_on) begin
                  phase_in      = PH_WAIT_ON;
                  tick_count_in = '0;
               end else if (off_count >= sync_off_ticks_ff) begin
                  phase_in       = PH_SAMPLE;
                  tick_count_in  = bit_period_ff >> 1;
                  bits_so_far_in = '0;
                  bit_index_in   = '0;
               end else begin
                  tick_count_in = off_count;
               end
            end
            PH_SAMPLE: begin
               if (tick_count_ff > 16'd1) begin
                  tick_count_in = tick_count_ff - 16'd1;
               end else begin
                  tick_count_in = bit_period_ff;
                  if (bit_index_ff == LAST_BIT_INDEX) begin
                     bits_so_far_in = '0;
                     bit_index_in   = '0;
                     rsp_valid_in   = 1'b1;
                     rsp_char_in    = decode_letter(bits_next);
                     rsp_pattern_in = bits_next;
                  end else begin
                     bits_so_far_in = bits_next;
                     bit_index_in   = bit_index_ff + 3'd1;
                  end
               end
            end
            default: phase_in = PH_WAIT_ON;
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         on_threshold_ff   <= ON_THRESHOLD_RST;
         bit_period_ff     <= BIT_PERIOD_RST;
         sync_off_ticks_ff <= SYNC_OFF_TICKS_RST;
         in_valid_ff       <= 1'b0;
         phase_ff          <= PH_WAIT_ON;
         tick_count_ff     <= '0;
         bits_so_far_ff    <= '0;
         bit_index_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         on_threshold_ff   <= on_threshold_in;
         bit_period_ff     <= bit_period_in;
         sync_off_ticks_ff <= sync_off_ticks_in;
         in_valid_ff       <= in_valid_in;
         phase_ff          <= phase_in;
         tick_count_ff     <= tick_count_in;
         bits_so_far_ff    <= bits_so_far_in;
         bit_index_ff      <= bit_index_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      in_level_ff    <= in_level_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_pattern_ff <= rsp_pattern_in;
   end

endmodule

/* hdl/ofblr_checker.sv */
module ofblr_checker
   import ofblr_pkg::*;
(
   input logic          clock,
   input logic          reset,
   ofblr_req_if.sink    req_chan,
   ofblr_rsp_if.source  rsp_chan,
   ofblr_csr_if.sink    csr_chan
);

   // character always agrees with the pattern it came from
   a_char_matches_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.character == decode_letter(rsp_chan.bit_pattern))
      else $error("character does not match bit pattern");

   // a fresh letter follows an earlier sample transaction
   a_rsp_from_sample: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(req_chan.valid && req_chan.ready, 2))
      else $error("letter without a sample transaction");

   // register port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_chan.valid |-> csr_chan.ready)
      else $error("register write stalled");

   // stalled letter holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.character) && $stable(rsp_chan.bit_pattern))
      else $error("stalled letter changed");

endmodule

bind optical_five_bit_letter_receiver_unit ofblr_checker u_ofblr_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan),
   .csr_chan (csr_chan)
);
